FILE: hdl/tcpfrs_pkg.sv
`timescale 1ns / 1ps
// tcpfrs_pkg: types, constants and flow entry layout for the per-flow
// header normalizer; used by every module of the block, not by the interfaces

package tcpfrs_pkg;

  // flow table geometry
  localparam int unsigned FLOW_ENTRIES = 256;
  localparam int unsigned FlowIdxW     = $clog2(FLOW_ENTRIES);

  // packet count saturates here
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  // bit of the tcp flag byte that marks ACK
  localparam int unsigned AckBit = 4;

  // udp payload length is total length minus this
  localparam logic [17:0] UdpHeaderBytes = 18'd8;

  // learned bits of a flow entry
  localparam int unsigned LrnFwd = 0;
  localparam int unsigned LrnRev = 1;

  // record kinds
  localparam logic RecPacket   = 1'b0;
  localparam logic RecIcmpNote = 1'b1;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_ABS_TIME = 1'b0,
    CFG_ABS_SEQ  = 1'b1
  } cfg_idx_e;

  typedef logic [FlowIdxW-1:0] flow_idx_t;

  typedef struct packed {
    logic abs_time;
    logic abs_seq;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  flow_slot;
    logic        new_flow;
    logic        direction;
    logic        is_tcp;
    logic        icmp_err;
    logic [63:0] timestamp;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  hdr_flags;
    logic [15:0] ip_total_length;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
  } pkt_t;

  typedef struct packed {
    logic        record_kind;
    logic [63:0] relative_time;
    logic [31:0] relative_seq;
    logic [31:0] relative_ack;
    logic [15:0] payload_length;
    logic        malformed;
    logic [31:0] packet_count;
  } rec_t;

  typedef struct packed {
    logic [1:0]  learned;
    logic [31:0] base_fwd;
    logic [31:0] base_rev;
    logic [63:0] start_time;
    logic [31:0] count;
  } flow_entry_t;

  // flow table slot of a packet
  function automatic flow_idx_t slot_index(input logic [7:0] slot);
    slot_index = flow_idx_t'(slot);
  endfunction

endpackage

FILE: hdl/tcpfrs_if.sv
`timescale 1ns / 1ps
// tcpfrs_pkt_if and tcpfrs_rec_if: valid/ready channels for packet headers
// and result records; widths follow the header fields, no package needed

interface tcpfrs_pkt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  flow_slot;
  logic        new_flow;
  logic        direction;
  logic        is_tcp;
  logic        icmp_err;
  logic [63:0] timestamp;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [7:0]  hdr_flags;
  logic [15:0] ip_total_length;
  logic [3:0]  ip_header_words;
  logic [3:0]  tcp_header_words;

  modport source (
    output valid, flow_slot, new_flow, direction, is_tcp, icmp_err, timestamp,
           seq_number, ack_number, hdr_flags, ip_total_length, ip_header_words,
           tcp_header_words,
    input  ready
  );

  modport sink (
    input  valid, flow_slot, new_flow, direction, is_tcp, icmp_err, timestamp,
           seq_number, ack_number, hdr_flags, ip_total_length, ip_header_words,
           tcp_header_words,
    output ready
  );
endinterface

interface tcpfrs_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [63:0] relative_time;
  logic [31:0] relative_seq;
  logic [31:0] relative_ack;
  logic [15:0] payload_length;
  logic        malformed;
  logic [31:0] packet_count;

  modport source (
    output valid, record_kind, relative_time, relative_seq, relative_ack,
           payload_length, malformed, packet_count,
    input  ready
  );

  modport sink (
    input  valid, record_kind, relative_time, relative_seq, relative_ack,
           payload_length, malformed, packet_count,
    output ready
  );
endinterface

FILE: hdl/tcpfrs_flow_mem.sv
`timescale 1ns / 1ps
// tcpfrs_flow_mem: flow table, one write port and one registered read port
// depends on tcpfrs_pkg for the entry layout and table depth

module tcpfrs_flow_mem import tcpfrs_pkg::*; (
  input  logic        clk_i,
  input  logic        we_i,
  input  flow_idx_t   waddr_i,
  input  flow_entry_t wdata_i,
  input  logic        re_i,
  input  flow_idx_t   raddr_i,
  output flow_entry_t rdata_o
);

  flow_entry_t mem [FLOW_ENTRIES];
  flow_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tcpfrs_update.sv
`timescale 1ns / 1ps
// tcpfrs_update: per-packet flow entry update and result record, combinational
// depends on tcpfrs_pkg for packet, record, entry and config types

module tcpfrs_update import tcpfrs_pkg::*; (
  input  cfg_t        cfg_i,
  input  pkt_t        pkt_i,
  input  flow_entry_t entry_i,
  output flow_entry_t entry_o,
  output rec_t        rec_o
);

  flow_entry_t base;
  flow_entry_t upd;
  logic        own_bit;
  logic        oth_bit;
  logic [31:0] own_base;
  logic [31:0] oth_base;
  logic [17:0] len;
  logic        ack_set;

  always_comb begin
    // fresh entry on a new flow
    base = entry_i;
    if (pkt_i.new_flow) begin
      base.start_time = cfg_i.abs_time ? 64'd0 : pkt_i.timestamp - 64'd1;
      base.learned    = cfg_i.abs_seq ? 2'b11 : 2'b00;
      base.base_fwd   = '0;
      base.base_rev   = '0;
      base.count      = '0;
    end

    upd       = base;
    upd.count = (base.count == CountMax) ? base.count : base.count + 32'd1;

    // learned bits of this and the other direction
    own_bit  = pkt_i.direction ? base.learned[LrnRev] : base.learned[LrnFwd];
    oth_bit  = pkt_i.direction ? base.learned[LrnFwd] : base.learned[LrnRev];
    own_base = pkt_i.direction ? base.base_rev : base.base_fwd;
    oth_base = pkt_i.direction ? base.base_fwd : base.base_rev;
    ack_set  = pkt_i.hdr_flags[AckBit];

    rec_o                = '0;
    rec_o.record_kind    = pkt_i.icmp_err ? RecIcmpNote : RecPacket;
    rec_o.relative_time  = pkt_i.timestamp - base.start_time;
    rec_o.packet_count   = upd.count;
    len                  = '0;

    if (!pkt_i.icmp_err) begin
      if (pkt_i.is_tcp) begin
        // learn own base from the first seq
        if (!own_bit) begin
          own_base = pkt_i.seq_number;
        end
        // learn the other base from the first ack
        if (ack_set && !oth_bit) begin
          oth_base = pkt_i.ack_number;
        end
        if (pkt_i.direction) begin
          upd.learned[LrnRev] = 1'b1;
          upd.base_rev        = own_base;
          if (ack_set) begin
            upd.learned[LrnFwd] = 1'b1;
            upd.base_fwd        = oth_base;
          end
        end else begin
          upd.learned[LrnFwd] = 1'b1;
          upd.base_fwd        = own_base;
          if (ack_set) begin
            upd.learned[LrnRev] = 1'b1;
            upd.base_rev        = oth_base;
          end
        end
        rec_o.relative_seq = pkt_i.seq_number - own_base;
        rec_o.relative_ack = ack_set ? pkt_i.ack_number - oth_base : 32'd0;
        len = {2'b00, pkt_i.ip_total_length}
            - {12'd0, pkt_i.ip_header_words, 2'b00}
            - {12'd0, pkt_i.tcp_header_words, 2'b00};
      end else begin
        len = {2'b00, pkt_i.ip_total_length} - UdpHeaderBytes;
      end
      // negative length clamps to zero
      rec_o.malformed      = len[17];
      rec_o.payload_length = len[17] ? 16'd0 : len[15:0];
    end

    entry_o = upd;
  end

endmodule

FILE: hdl/tcp_flow_relative_sequence_unit.sv
`timescale 1ns / 1ps
// tcp_flow_relative_sequence_unit: per-flow header normalizer, top level
// a header word is registered in stage 1 and its result word in the result
// register; throughput: one word per cycle unless the output stalls, set by
// the flow table read-modify-write with a one-entry bypass for back-to-back
// packets of the same flow
// reset: clears pipeline valids and mode registers; flow table contents are
// undefined until a new-flow packet writes the slot
// depends on tcpfrs_pkg, tcpfrs_if, tcpfrs_flow_mem and tcpfrs_update

module tcp_flow_relative_sequence_unit import tcpfrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [0:0]          cfg_data_i,
  tcpfrs_pkt_if.sink          pkt_i,
  tcpfrs_rec_if.source        rec_o
);

  cfg_t        cfg_q;
  pkt_t        in_pkt;
  pkt_t        s1_pkt_q;
  logic        s1_valid_q;
  logic        fwd_hit_q;
  flow_entry_t fwd_entry_q;
  flow_entry_t mem_rdata;
  flow_entry_t cur_entry;
  flow_entry_t new_entry;
  rec_t        s1_rec;
  rec_t        out_rec_q;
  logic        out_valid_q;
  logic        out_free;
  logic        advance;
  logic        accept;
  logic        wr_en;
  cfg_idx_e    cfg_sel;

  // configuration registers
  assign cfg_sel = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_sel)
        CFG_ABS_TIME: cfg_q.abs_time <= cfg_data_i[0];
        CFG_ABS_SEQ:  cfg_q.abs_seq  <= cfg_data_i[0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // input word gathered into one struct
  assign in_pkt = '{
    flow_slot:        pkt_i.flow_slot,
    new_flow:         pkt_i.new_flow,
    direction:        pkt_i.direction,
    is_tcp:           pkt_i.is_tcp,
    icmp_err:         pkt_i.icmp_err,
    timestamp:        pkt_i.timestamp,
    seq_number:       pkt_i.seq_number,
    ack_number:       pkt_i.ack_number,
    hdr_flags:        pkt_i.hdr_flags,
    ip_total_length:  pkt_i.ip_total_length,
    ip_header_words:  pkt_i.ip_header_words,
    tcp_header_words: pkt_i.tcp_header_words
  };

  // pipeline handshake
  assign out_free    = !out_valid_q || rec_o.ready;
  assign advance     = !s1_valid_q || out_free;
  assign accept      = pkt_i.valid && advance;
  assign wr_en       = s1_valid_q && out_free;
  assign pkt_i.ready = advance;

  // flow table
  tcpfrs_flow_mem u_flow_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_index(s1_pkt_q.flow_slot)),
    .wdata_i (new_entry),
    .re_i    (accept),
    .raddr_i (slot_index(pkt_i.flow_slot)),
    .rdata_o (mem_rdata)
  );

  // bypass the entry written at the same edge as our read
  assign cur_entry = fwd_hit_q ? fwd_entry_q : mem_rdata;

  tcpfrs_update u_update (
    .cfg_i   (cfg_q),
    .pkt_i   (s1_pkt_q),
    .entry_i (cur_entry),
    .entry_o (new_entry),
    .rec_o   (s1_rec)
  );

  // stage 1: header register and bypass capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_q <= accept;
      end
      if (accept) begin
        fwd_hit_q <= wr_en &&
                     (slot_index(s1_pkt_q.flow_slot) == slot_index(pkt_i.flow_slot));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pkt_q    <= in_pkt;
      fwd_entry_q <= new_entry;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_rec_q <= s1_rec;
    end
  end

  assign rec_o.valid          = out_valid_q;
  assign rec_o.record_kind    = out_rec_q.record_kind;
  assign rec_o.relative_time  = out_rec_q.relative_time;
  assign rec_o.relative_seq   = out_rec_q.relative_seq;
  assign rec_o.relative_ack   = out_rec_q.relative_ack;
  assign rec_o.payload_length = out_rec_q.payload_length;
  assign rec_o.malformed      = out_rec_q.malformed;
  assign rec_o.packet_count   = out_rec_q.packet_count;

endmodule
